@@ rtl/core/assert_macros.svh @@
// assertion macros used by the top level of the rank table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cfrt_pkg.sv @@
// shared constants and types of the context frequency rank table
package cfrt_pkg;

  localparam int CONTEXTS_DEF = 256;
  localparam int SYMBOLS_DEF  = 16;

  localparam int COUNT_W = 8;
  localparam int ANSWER_W = 4;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 8'hff;

  localparam logic [1:0] ACT_UPDATE = 2'd0;
  localparam logic [1:0] ACT_RANK   = 2'd1;
  localparam logic [1:0] ACT_SYMBOL = 2'd2;

  typedef struct packed {
    logic cnt;
    logic rnk;
    logic sym;
  } mem_we_t;

endpackage

@@ rtl/core/cfrt_tables.sv @@
// count, rank and symbol memories with the clearing sweep after reset
module cfrt_tables import cfrt_pkg::*; #(
  parameter int CONTEXTS = CONTEXTS_DEF,
  parameter int SYMBOLS  = SYMBOLS_DEF
) (
  input  logic clk,
  input  logic rst,
  output logic ready,
  input  mem_we_t we,
  input  logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] cnt_waddr,
  input  logic [COUNT_W-1:0] cnt_wdata,
  input  logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] cnt_raddr,
  output logic [COUNT_W-1:0] cnt_rdata,
  input  logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] rank_waddr,
  input  logic [$clog2(SYMBOLS)-1:0] rank_wdata,
  input  logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] rank_raddr,
  output logic [$clog2(SYMBOLS)-1:0] rank_rdata,
  input  logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] sym_waddr,
  input  logic [$clog2(SYMBOLS)-1:0] sym_wdata,
  input  logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] sym_raddr,
  output logic [$clog2(SYMBOLS)-1:0] sym_rdata
);

  localparam int SYM_W = $clog2(SYMBOLS);
  localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int AW    = CTX_W + SYM_W;
  localparam int DEPTH = CONTEXTS * (1 << SYM_W);

  logic [COUNT_W-1:0] cnt_mem  [DEPTH];
  logic [SYM_W-1:0]   rank_mem [DEPTH];
  logic [SYM_W-1:0]   sym_mem  [DEPTH];

  logic             clearing;
  logic [CTX_W-1:0] cctx;
  logic [SYM_W-1:0] csym;
  logic [AW-1:0]    caddr;

  assign caddr = {cctx, csym};
  assign ready = !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      cctx     <= '0;
      csym     <= '0;
    end else if (clearing) begin
      if (csym == SYM_W'(SYMBOLS - 1)) begin
        csym <= '0;
        if (cctx == CTX_W'(CONTEXTS - 1)) begin
          clearing <= 1'b0;
        end else begin
          cctx <= cctx + 1'b1;
        end
      end else begin
        csym <= csym + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      cnt_mem[caddr]  <= '0;
      rank_mem[caddr] <= csym;
      sym_mem[caddr]  <= csym;
    end else begin
      if (we.cnt) begin
        cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (we.rnk) begin
        rank_mem[rank_waddr] <= rank_wdata;
      end
      if (we.sym) begin
        sym_mem[sym_waddr] <= sym_wdata;
      end
    end
    cnt_rdata  <= cnt_mem[cnt_raddr];
    rank_rdata <= rank_mem[rank_raddr];
    sym_rdata  <= sym_mem[sym_raddr];
  end

endmodule

@@ rtl/core/cfrt_seq.sv @@
// sequencer: update with halving pass, rank walk and swap, and the two queries
module cfrt_seq import cfrt_pkg::*; #(
  parameter int CONTEXTS = CONTEXTS_DEF,
  parameter int SYMBOLS  = SYMBOLS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic tables_ready,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] action,
  input  logic [7:0] context_req,
  input  logic [3:0] operand,
  output logic res_valid,
  output logic [ANSWER_W-1:0] res_answer,
  input  logic res_take,
  output mem_we_t we,
  output logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] cnt_waddr,
  output logic [COUNT_W-1:0] cnt_wdata,
  output logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] cnt_raddr,
  input  logic [COUNT_W-1:0] cnt_rdata,
  output logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] rank_waddr,
  output logic [$clog2(SYMBOLS)-1:0] rank_wdata,
  output logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] rank_raddr,
  input  logic [$clog2(SYMBOLS)-1:0] rank_rdata,
  output logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] sym_waddr,
  output logic [$clog2(SYMBOLS)-1:0] sym_wdata,
  output logic [((CONTEXTS > 1) ? $clog2(CONTEXTS) : 1) + $clog2(SYMBOLS) - 1:0] sym_raddr,
  input  logic [$clog2(SYMBOLS)-1:0] sym_rdata
);

  localparam int SYM_W = $clog2(SYMBOLS);
  localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;

  typedef enum logic [3:0] {
    IDLE, LOAD, EVAL, HALVE, HALVE_LAST, WALK_START, WALK_SYM, WALK_CNT, WALK_CMP,
    SWAP1, SWAP2, RESULT
  } state_t;

  state_t state;
  logic [1:0]          act;
  logic [CTX_W-1:0]    ctx;
  logic [SYM_W-1:0]    sym_op;
  logic [SYM_W-1:0]    rnk;
  logic [SYM_W-1:0]    ptr;
  logic [SYM_W-1:0]    wptr;
  logic                hv;
  logic [SYM_W-1:0]    target;
  logic [SYM_W-1:0]    s_lo;
  logic [SYM_W-1:0]    cand;
  logic                found;
  logic [COUNT_W-1:0]  cnt_sym;
  logic [ANSWER_W-1:0] ans;

  logic               accept;
  logic               item_ok;
  logic [COUNT_W-1:0] cnt_new;

  assign in_stall   = !(state == IDLE && tables_ready);
  assign accept     = in_valid && !in_stall;
  assign item_ok    = ({24'd0, context_req} < 32'(CONTEXTS)) &&
                      ({28'd0, operand} < 32'(SYMBOLS)) &&
                      (action == ACT_UPDATE || action == ACT_RANK || action == ACT_SYMBOL);
  assign cnt_new    = cnt_rdata + 8'd1;
  assign res_valid  = (state == RESULT);
  assign res_answer = ans;

  // read addresses
  always_comb begin
    cnt_raddr  = {ctx, sym_op};
    rank_raddr = {ctx, sym_op};
    sym_raddr  = {ctx, sym_op};
    case (state)
      HALVE:    cnt_raddr = {ctx, ptr};
      WALK_SYM: sym_raddr = {ctx, ptr - SYM_W'(1)};
      WALK_CNT: cnt_raddr = {ctx, sym_rdata};
      WALK_CMP: sym_raddr = {ctx, ptr - SYM_W'(2)};
      default: ;
    endcase
  end

  // write ports
  always_comb begin
    we         = '0;
    cnt_waddr  = {ctx, sym_op};
    cnt_wdata  = cnt_new;
    rank_waddr = {ctx, sym_op};
    rank_wdata = target;
    sym_waddr  = {ctx, rnk};
    sym_wdata  = s_lo;
    case (state)
      EVAL: begin
        we.cnt = (act == ACT_UPDATE);
      end
      HALVE, HALVE_LAST: begin
        we.cnt    = hv;
        cnt_waddr = {ctx, wptr};
        cnt_wdata = cnt_rdata >> 1;
      end
      SWAP1: begin
        we.rnk = 1'b1;
        we.sym = 1'b1;
      end
      SWAP2: begin
        we.rnk     = 1'b1;
        we.sym     = 1'b1;
        rank_waddr = {ctx, s_lo};
        rank_wdata = rnk;
        sym_waddr  = {ctx, target};
        sym_wdata  = sym_op;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: begin
          if (accept) begin
            act    <= action;
            ctx    <= CTX_W'(context_req);
            sym_op <= SYM_W'(operand);
            ans    <= '0;
            state  <= item_ok ? LOAD : RESULT;
          end
        end
        LOAD: begin
          state <= EVAL;
        end
        EVAL: begin
          case (act)
            ACT_RANK: begin
              ans   <= ANSWER_W'(rank_rdata);
              state <= RESULT;
            end
            ACT_SYMBOL: begin
              ans   <= ANSWER_W'(sym_rdata);
              state <= RESULT;
            end
            default: begin
              rnk <= rank_rdata;
              hv  <= 1'b0;
              ptr <= '0;
              if (cnt_new == COUNT_LIMIT) begin
                cnt_sym <= cnt_new >> 1;
                state   <= HALVE;
              end else begin
                cnt_sym <= cnt_new;
                state   <= WALK_START;
              end
            end
          endcase
        end
        HALVE: begin
          hv   <= 1'b1;
          wptr <= ptr;
          if (ptr == SYM_W'(SYMBOLS - 1)) begin
            state <= HALVE_LAST;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        HALVE_LAST: begin
          state <= WALK_START;
        end
        WALK_START: begin
          if (rnk == '0) begin
            ans   <= '0;
            state <= RESULT;
          end else begin
            ptr   <= rnk;
            found <= 1'b0;
            state <= WALK_SYM;
          end
        end
        WALK_SYM: begin
          state <= WALK_CNT;
        end
        WALK_CNT: begin
          cand  <= sym_rdata;
          state <= WALK_CMP;
        end
        WALK_CMP: begin
          if (cnt_sym > cnt_rdata) begin
            target <= ptr - 1'b1;
            s_lo   <= cand;
            found  <= 1'b1;
            ptr    <= ptr - 1'b1;
            state  <= (ptr == SYM_W'(1)) ? SWAP1 : WALK_CNT;
          end else if (found) begin
            state <= SWAP1;
          end else begin
            ans   <= ANSWER_W'(rnk);
            state <= RESULT;
          end
        end
        SWAP1: begin
          state <= SWAP2;
        end
        SWAP2: begin
          ans   <= ANSWER_W'(target);
          state <= RESULT;
        end
        RESULT: begin
          if (res_take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/context_frequency_rank_table_core.sv @@
// top level of the context frequency rank table
//
// Input channel in_valid/in_stall carries action, context_req and operand;
// output channel out_valid/out_stall carries answer, one result per input
// transfer, in order. Action 0 counts the symbol and moves it toward rank 0
// past lower counts, action 1 reads the rank of a symbol, action 2 reads the
// symbol at a rank; anything out of range answers 0 and changes nothing.
// One item is in work at a time; in_stall stays high until it is done.
// An update writes the new count, halves all counts of the context when it
// hits 255, then walks from the symbol's rank toward rank 0 and swaps it
// with the symbol at the target rank when it moves; a query reads one map
// entry.
// The count, rank and symbol memories each give one read and one write a
// cycle, and the walk is bounded by the dependent symbol then count read.
// After reset a clearing pass sets counts to zero and both maps to
// identity; in_stall is high throughout.
// The output register holds a result while out_stall is high; the next
// item may be accepted meanwhile, its result waits until the register frees.
`include "assert_macros.svh"

module context_frequency_rank_table_core import cfrt_pkg::*; #(
  parameter int CONTEXTS = CONTEXTS_DEF,
  parameter int SYMBOLS  = SYMBOLS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] action,
  input  logic [7:0] context_req,
  input  logic [3:0] operand,
  output logic out_valid,
  input  logic out_stall,
  output logic [ANSWER_W-1:0] answer
);

  localparam int SYM_W = $clog2(SYMBOLS);
  localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int AW    = CTX_W + SYM_W;

  logic                tables_ready;
  logic                res_valid;
  logic [ANSWER_W-1:0] res_answer;
  logic                res_take;
  mem_we_t             we;
  logic [AW-1:0]       cnt_waddr, cnt_raddr;
  logic [COUNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic [AW-1:0]       rank_waddr, rank_raddr;
  logic [SYM_W-1:0]    rank_wdata, rank_rdata;
  logic [AW-1:0]       sym_waddr, sym_raddr;
  logic [SYM_W-1:0]    sym_wdata, sym_rdata;

  cfrt_tables #(.CONTEXTS(CONTEXTS), .SYMBOLS(SYMBOLS)) u_tables (
    .clk        (clk),
    .rst        (rst),
    .ready      (tables_ready),
    .we         (we),
    .cnt_waddr  (cnt_waddr),
    .cnt_wdata  (cnt_wdata),
    .cnt_raddr  (cnt_raddr),
    .cnt_rdata  (cnt_rdata),
    .rank_waddr (rank_waddr),
    .rank_wdata (rank_wdata),
    .rank_raddr (rank_raddr),
    .rank_rdata (rank_rdata),
    .sym_waddr  (sym_waddr),
    .sym_wdata  (sym_wdata),
    .sym_raddr  (sym_raddr),
    .sym_rdata  (sym_rdata)
  );

  cfrt_seq #(.CONTEXTS(CONTEXTS), .SYMBOLS(SYMBOLS)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .tables_ready (tables_ready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .context_req  (context_req),
    .operand      (operand),
    .res_valid    (res_valid),
    .res_answer   (res_answer),
    .res_take     (res_take),
    .we           (we),
    .cnt_waddr    (cnt_waddr),
    .cnt_wdata    (cnt_wdata),
    .cnt_raddr    (cnt_raddr),
    .cnt_rdata    (cnt_rdata),
    .rank_waddr   (rank_waddr),
    .rank_wdata   (rank_wdata),
    .rank_raddr   (rank_raddr),
    .rank_rdata   (rank_rdata),
    .sym_waddr    (sym_waddr),
    .sym_wdata    (sym_wdata),
    .sym_raddr    (sym_raddr),
    .sym_rdata    (sym_rdata)
  );

  // output register
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      answer <= res_answer;
    end
  end

  `ASSERT_IMPLY(a_stall_while_clearing, !tables_ready, in_stall, "input taken during clearing")
  `ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "second item taken while busy")
  `ASSERT_IMPLY(a_no_result_when_idle, in_valid && !in_stall, !res_valid, "result pending at input transfer")
  `ASSERT_NEXT(a_result_lands, res_take, out_valid && answer == $past(res_answer), "result not registered")

endmodule

@@ bench/tb_top.sv @@
// testbench for the context frequency rank table: directed rows, then random traffic checked by a predictor
`timescale 1ns / 100ps

module tb_top;
  import cfrt_pkg::*;

  localparam int N_CTX = CONTEXTS_DEF;
  localparam int N_SYM = SYMBOLS_DEF;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int N_ROWS = 20;
  localparam int ITEMS_PER_PHASE = 450;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] ctx;
    logic [3:0] opnd;
    logic typed;
    logic [ANSWER_W-1:0] ans;
  } rank_row_t;

  typedef struct packed {
    logic [1:0] act;
    logic [7:0] ctx;
    logic [3:0] opnd;
    logic [ANSWER_W-1:0] ans;
  } rank_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_RANK;
  logic [7:0] context_req = '0;
  logic [3:0] operand = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ANSWER_W-1:0] answer;

  logic [COUNT_W-1:0] freq_count [N_CTX*N_SYM];
  logic [3:0] rank_by_sym [N_CTX*N_SYM];
  logic [3:0] sym_by_rank [N_CTX*N_SYM];

  rank_reply_t answers_due [$];
  rank_row_t directed_rows [N_ROWS];

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  logic hold_active = 1'b0;
  int mismatches = 0;
  int answers_seen = 0;
  int items_sent = 0;
  int updates_sent = 0;
  int halvings = 0;
  logic [7:0] hot_ctx;
  logic [3:0] hot_sym;
  logic [7:0] warm_ctx [4];

  context_frequency_rank_table_core u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .context_req(context_req),
    .operand(operand),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .answer(answer)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [ANSWER_W-1:0] apply_rank_action(input logic [1:0] act,
                                                              input logic [7:0] ctx,
                                                              input logic [3:0] opnd);
    int base;
    int rk;
    int tgt;
    int k;
    bit moved;
    logic [3:0] other;
    logic [3:0] s_hi;
    logic [3:0] s_lo;
    logic [COUNT_W-1:0] cnt;
    base = int'(ctx) * N_SYM;
    case (act)
      ACT_UPDATE: begin
        freq_count[base + opnd] = freq_count[base + opnd] + 1'b1;
        if (freq_count[base + opnd] == COUNT_LIMIT) begin
          halvings++;
          for (k = 0; k < N_SYM; k++) freq_count[base + k] = freq_count[base + k] >> 1;
        end
        rk = rank_by_sym[base + opnd];
        if (rk == 0) return '0;
        cnt = freq_count[base + opnd];
        tgt = rk;
        moved = 1'b0;
        for (k = rk; k > 0; k--) begin
          other = sym_by_rank[base + k - 1];
          if (cnt > freq_count[base + other]) begin
            tgt = k - 1;
            moved = 1'b1;
          end else begin
            break;
          end
        end
        if (!moved) return 4'(rk);
        s_hi = sym_by_rank[base + rk];
        s_lo = sym_by_rank[base + tgt];
        rank_by_sym[base + s_hi] = 4'(tgt);
        rank_by_sym[base + s_lo] = 4'(rk);
        sym_by_rank[base + rk] = s_lo;
        sym_by_rank[base + tgt] = s_hi;
        return 4'(tgt);
      end
      ACT_RANK: return rank_by_sym[base + opnd];
      ACT_SYMBOL: return sym_by_rank[base + opnd];
      default: return '0;
    endcase
  endfunction

  task automatic put_item(input logic [1:0] a, input logic [7:0] c, input logic [3:0] o,
                          input logic typed, input logic [ANSWER_W-1:0] typed_ans);
    rank_reply_t r;
    logic [ANSWER_W-1:0] p;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a;
    context_req <= c;
    operand <= o;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = apply_rank_action(a, c, o);
    r.act = a;
    r.ctx = c;
    r.opnd = o;
    r.ans = typed ? typed_ans : p;
    answers_due.push_back(r);
    items_sent++;
    if (a == ACT_UPDATE) updates_sent++;
  endtask

  task automatic send_random();
    logic [1:0] a;
    logic [7:0] c;
    logic [3:0] o;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) a = ACT_UNUSED;
    else if (pick < 20) a = ACT_RANK;
    else if (pick < 32) a = ACT_SYMBOL;
    else a = ACT_UPDATE;
    pick = $urandom_range(0, 99);
    if (pick < 60) c = hot_ctx;
    else if (pick < 80) c = warm_ctx[$urandom_range(0, 3)];
    else c = 8'($urandom_range(0, 255));
    if (a == ACT_UPDATE && $urandom_range(0, 99) < 45) o = hot_sym;
    else o = 4'($urandom_range(0, 15));
    put_item(a, c, o, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  // output side: check transfers, then pick the next stall
  always @(posedge clk) begin
    rank_reply_t e;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      answers_seen++;
      if (answers_due.size() == 0) begin
        flag_mismatch($sformatf("answer %0d with nothing pending", answer));
      end else begin
        e = answers_due.pop_front();
        if (answer !== e.ans)
          flag_mismatch($sformatf("act %0d ctx %0d opnd %0d: answer %0d, want %0d",
                                  e.act, e.ctx, e.opnd, answer, e.ans));
      end
    end
    out_stall <= hold_active || ($urandom_range(0, 99) < stall_pct);
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d answers pending", answers_due.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    directed_rows = '{
      '{ACT_RANK,   8'd0,   4'd0,  1'b1, 4'd0},
      '{ACT_RANK,   8'd255, 4'd15, 1'b1, 4'd15},
      '{ACT_SYMBOL, 8'd128, 4'd15, 1'b1, 4'd15},
      '{ACT_SYMBOL, 8'd1,   4'd0,  1'b1, 4'd0},
      '{ACT_UNUSED, 8'd255, 4'd15, 1'b1, 4'd0},
      '{ACT_UNUSED, 8'd0,   4'd0,  1'b1, 4'd0},
      '{ACT_UPDATE, 8'd0,   4'd0,  1'b1, 4'd0},
      '{ACT_UPDATE, 8'd0,   4'd0,  1'b1, 4'd0},
      '{ACT_UPDATE, 8'd0,   4'd1,  1'b0, 4'd0},
      '{ACT_UPDATE, 8'd255, 4'd15, 1'b0, 4'd0},
      '{ACT_RANK,   8'd255, 4'd15, 1'b0, 4'd0},
      '{ACT_SYMBOL, 8'd255, 4'd15, 1'b0, 4'd0},
      '{ACT_RANK,   8'd255, 4'd0,  1'b0, 4'd0},
      '{ACT_UPDATE, 8'd255, 4'd7,  1'b0, 4'd0},
      '{ACT_UPDATE, 8'd255, 4'd7,  1'b0, 4'd0},
      '{ACT_SYMBOL, 8'd255, 4'd0,  1'b0, 4'd0},
      '{ACT_UPDATE, 8'd170, 4'd10, 1'b0, 4'd0},
      '{ACT_UPDATE, 8'd85,  4'd5,  1'b0, 4'd0},
      '{ACT_RANK,   8'd85,  4'd5,  1'b0, 4'd0},
      '{ACT_UNUSED, 8'd170, 4'd10, 1'b1, 4'd0}
    };
    for (int i = 0; i < N_CTX * N_SYM; i++) begin
      freq_count[i] = '0;
      rank_by_sym[i] = 4'(i % N_SYM);
      sym_by_rank[i] = 4'(i % N_SYM);
    end
    hot_ctx = 8'($urandom_range(0, 255));
    hot_sym = 4'($urandom_range(1, 15));
    for (int i = 0; i < 4; i++) warm_ctx[i] = 8'($urandom_range(0, 255));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_ROWS; i++)
      put_item(directed_rows[i].act, directed_rows[i].ctx, directed_rows[i].opnd,
               directed_rows[i].typed, directed_rows[i].ans);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct <= 0;
          hold_req = 1'b1;
        end
        1: begin
          send_idle_pct = 45;
          stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct <= 45;
        end
        default: begin
          send_idle_pct = 34;
          stall_pct <= 34;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_random();
      drain();
    end

    repeat (60) @(posedge clk);
    $display("%0d items (%0d updates) in four traffic phases, %0d answers checked",
             items_sent, updates_sent, answers_seen);
    $display("%0d count halvings seen, hot context %0d symbol %0d", halvings, hot_ctx, hot_sym);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
